@@ src/lrum_pkg.sv @@
// ----------------------------------------------------------------------------
// lrum_pkg
// Shared constants and helpers for the LRU matrix page replacement unit.
// ----------------------------------------------------------------------------
package lrum_pkg;

  // default configuration
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // largest supported frame count, and the width of a row count at that size
  localparam int FRAMES_MAX    = 32;
  localparam int CNT_MAX_W     = 6;

  // fixed field widths on the stream ports
  localparam int IN_PAGE_W     = 16;
  localparam int OUT_FRAME_W   = 3;
  localparam int OUT_PAGE_W    = 16;
  localparam int OUT_FIELDS_W  = 1 + OUT_FRAME_W + 1 + OUT_PAGE_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // number of ones in a matrix row
  function automatic logic [CNT_MAX_W-1:0] count_ones(input logic [FRAMES_MAX-1:0] v);
    logic [CNT_MAX_W-1:0] n;
    n = '0;
    for (int i = 0; i < FRAMES_MAX; i++) begin
      n = n + CNT_MAX_W'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ src/lrum_victim_sel.sv @@
// ----------------------------------------------------------------------------
// lrum_victim_sel
// Picks the frame whose matrix row holds the fewest ones, lowest index on ties.
// ----------------------------------------------------------------------------
module lrum_victim_sel #(
  parameter int FRAMES = lrum_pkg::FRAMES_DEF
) (
  input  logic [FRAMES-1:0][FRAMES-1:0]                     age,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]    victim
);
  import lrum_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  logic [FRAMES-1:0][CNT_W-1:0] row_cnt;
  logic [CNT_W-1:0]             best_cnt;

  // per-row population counts
  always_comb begin
    for (int r = 0; r < FRAMES; r++) begin
      row_cnt[r] = CNT_W'(count_ones(FRAMES_MAX'(age[r])));
    end
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_comb begin
    victim   = '0;
    best_cnt = row_cnt[0];
    for (int r = 1; r < FRAMES; r++) begin
      if (row_cnt[r] < best_cnt) begin
        best_cnt = row_cnt[r];
        victim   = FIDX_W'(r);
      end
    end
  end

endmodule

@@ src/lru_matrix_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// lru_matrix_page_replacement_unit
// Page reference stream in, hit/fault report stream out, LRU matrix policy.
// ----------------------------------------------------------------------------
// One page reference is taken per clock while no result waits on out_tready.
// Its result enters the result register as it leaves the input register, so
// out_tvalid follows the handshake through the input and result registers.
// The tag compare against every frame, the row popcounts, the minimum search
// and the matrix update all sit in the single path between those registers,
// so the next reference sees the state left by the previous one without any
// stall. in_tready drops only while a result waits on out_tready. Reset clears
// the frame valid bits and the recency matrix at once; no sweep follows.
module lru_matrix_page_replacement_unit #(
  parameter int FRAMES    = lrum_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrum_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [15:0] page_number
  input  logic [lrum_pkg::IN_PAGE_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: [0] page_fault, [3:1] frame_index, [4] evicted_valid,
  //            [20:5] evicted_page, [23:21] zero
  output logic [lrum_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready
);
  import lrum_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // input stage
  logic                 s1_valid_r;
  logic [PAGE_BITS-1:0] s1_page_r;
  logic                 s1_fire;

  // frame table and recency matrix
  logic [FRAMES-1:0][PAGE_BITS-1:0] pages_r;
  logic [FRAMES-1:0]                valid_r, valid_nxt;
  logic [FRAMES-1:0][FRAMES-1:0]    age_r, age_nxt;

  // lookup
  logic [FRAMES-1:0] match;
  logic              hit;
  logic [FIDX_W-1:0] hit_idx, victim_idx, use_idx;
  logic [FRAMES-1:0] col_mask;

  // result register
  logic                  out_valid_r;
  logic                  out_fault_r;
  logic [FIDX_W-1:0]     out_frame_r;
  logic                  out_ev_valid_r;
  logic [PAGE_BITS-1:0]  out_ev_page_r;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_page_r <= PAGE_BITS'(in_tdata);
    end
  end

  // parallel tag compare against valid frames
  always_comb begin
    for (int f = 0; f < FRAMES; f++) begin
      match[f] = valid_r[f] && (pages_r[f] == s1_page_r);
    end
  end

  // lowest matching frame
  always_comb begin
    hit_idx = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (match[f]) begin
        hit_idx = FIDX_W'(f);
      end
    end
  end

  assign hit = |match;

  lrum_victim_sel #(
    .FRAMES (FRAMES)
  ) u_victim_sel (
    .age    (age_r),
    .victim (victim_idx)
  );

  assign use_idx  = hit ? hit_idx : victim_idx;
  assign col_mask = FRAMES'(1) << use_idx;

  // row of the used frame to all ones, its column cleared elsewhere
  always_comb begin
    valid_nxt          = valid_r;
    valid_nxt[use_idx] = 1'b1;
    for (int r = 0; r < FRAMES; r++) begin
      if (FIDX_W'(r) == use_idx) begin
        age_nxt[r] = '1;
      end else begin
        age_nxt[r] = age_r[r] & ~col_mask;
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      age_r   <= '0;
    end else if (s1_fire) begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !hit) begin
      pages_r[use_idx] <= s1_page_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_fault_r    <= !hit;
      out_frame_r    <= use_idx;
      out_ev_valid_r <= !hit && valid_r[use_idx];
      out_ev_page_r  <= (!hit && valid_r[use_idx]) ? pages_r[use_idx] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (OUT_TDATA_W - OUT_FIELDS_W)'(0),
    OUT_PAGE_W'(out_ev_page_r),
    out_ev_valid_r,
    OUT_FRAME_W'(out_frame_r),
    out_fault_r
  };

`ifndef ASSERT_OFF
  // a reference never matches two frames
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(match))
    else $error("page resident in more than one frame");

  // the frame used is resident afterwards
  a_used_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> valid_r[$past(use_idx)])
    else $error("used frame not valid after update");

  // the frame used becomes most recent
  a_row_ones: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (age_r[$past(use_idx)] == {FRAMES{1'b1}}))
    else $error("used frame row not all ones");

  // an eviction is only reported with a fault
  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_valid_r) |-> out_fault_r)
    else $error("eviction reported without a fault");

  // a hit leaves the evicted page at zero
  a_hit_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_fault_r) |-> (out_ev_page_r == '0))
    else $error("evicted page non-zero on a hit");
`endif

endmodule
